// File: rtl/core/decimal_field_to_scaled_code_unit_assert.svh
`ifndef DECIMAL_FIELD_TO_SCALED_CODE_UNIT_ASSERT_SVH
`define DECIMAL_FIELD_TO_SCALED_CODE_UNIT_ASSERT_SVH

// Assertion helpers used by the block's back-end module, dfsc_back.
`define DFSC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define DFSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/dfsc_pkg.sv
package dfsc_pkg;

  typedef struct packed {
    logic [7:0] field_char;
    logic       has_char;
    logic       last_of_field;
  } in_item_t;

  typedef struct packed {
    logic [63:0] stored_code;
    logic [2:0]  status;
    logic        missing_marker;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_INT     = 3'd1,
    PH_FRAC    = 3'd2,
    PH_EXPSIGN = 3'd3,
    PH_EXPDIG  = 3'd4
  } phase_t;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD      = 3'd1;
  localparam logic [2:0] ST_OFFSET   = 3'd2;
  localparam logic [2:0] ST_WIDTH    = 3'd3;
  localparam logic [2:0] ST_COLLIDE  = 3'd4;

  localparam logic [1:0] CFG_DEC     = 2'd0;
  localparam logic [1:0] CFG_OFFSET  = 2'd1;
  localparam logic [1:0] CFG_WIDTH   = 2'd2;
  localparam logic [1:0] CFG_MISSING = 2'd3;

  localparam logic [62:0] MANT_LIMIT = 63'd922337203685477579;
  localparam logic [13:0] EXP_STOP   = 14'd1000;
  localparam logic [14:0] FRAC_CAP   = 15'h7FFF;
  localparam logic [2:0]  IDX_CAP    = 3'd7;
  localparam logic [63:0] I64_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

  // Summary of a finished field, passed from parser to scaler.
  typedef struct packed {
    logic        is_mark;
    logic        bad;
    logic        negative;
    logic        round_up;
    logic [62:0] mantissa;
    logic signed [16:0] shift;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'd0,
    BK_MUL  = 3'd1,
    BK_DIV  = 3'd2,
    BK_OFS  = 3'd3,
    BK_OUT  = 3'd4
  } back_t;

  function automatic logic [63:0] ten_pow(input logic [4:0] k);
    logic [63:0] r;
    case (k)
      5'd0:  r = 64'd1;
      5'd1:  r = 64'd10;
      5'd2:  r = 64'd100;
      5'd3:  r = 64'd1000;
      5'd4:  r = 64'd10000;
      5'd5:  r = 64'd100000;
      5'd6:  r = 64'd1000000;
      5'd7:  r = 64'd10000000;
      5'd8:  r = 64'd100000000;
      5'd9:  r = 64'd1000000000;
      5'd10: r = 64'd10000000000;
      5'd11: r = 64'd100000000000;
      5'd12: r = 64'd1000000000000;
      5'd13: r = 64'd10000000000000;
      5'd14: r = 64'd100000000000000;
      5'd15: r = 64'd1000000000000000;
      5'd16: r = 64'd10000000000000000;
      5'd17: r = 64'd100000000000000000;
      5'd18: r = 64'd1000000000000000000;
      default: r = 64'd1;
    endcase
    return r;
  endfunction

  // Largest mantissa that can be scaled up by 10^k without passing INT64_MAX.
  function automatic logic [63:0] mul_limit(input logic [4:0] k);
    logic [63:0] r;
    case (k)
      5'd0:  r = I64_MAX;
      5'd1:  r = I64_MAX / 64'd10;
      5'd2:  r = I64_MAX / 64'd100;
      5'd3:  r = I64_MAX / 64'd1000;
      5'd4:  r = I64_MAX / 64'd10000;
      5'd5:  r = I64_MAX / 64'd100000;
      5'd6:  r = I64_MAX / 64'd1000000;
      5'd7:  r = I64_MAX / 64'd10000000;
      5'd8:  r = I64_MAX / 64'd100000000;
      5'd9:  r = I64_MAX / 64'd1000000000;
      5'd10: r = I64_MAX / 64'd10000000000;
      5'd11: r = I64_MAX / 64'd100000000000;
      5'd12: r = I64_MAX / 64'd1000000000000;
      5'd13: r = I64_MAX / 64'd10000000000000;
      5'd14: r = I64_MAX / 64'd100000000000000;
      5'd15: r = I64_MAX / 64'd1000000000000000;
      5'd16: r = I64_MAX / 64'd10000000000000000;
      5'd17: r = I64_MAX / 64'd100000000000000000;
      5'd18: r = I64_MAX / 64'd1000000000000000000;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/dfsc_front.sv
module dfsc_front
  import dfsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  input  logic [4:0] decimal_places,
  output logic      job_valid,
  input  logic      job_ready,
  output job_t      job
);

  phase_t      phase_r, phase_nxt;
  logic        neg_r, neg_nxt;
  logic [62:0] mant_r, mant_nxt;
  logic [14:0] frac_r, frac_nxt;
  logic        dseen_r, dseen_nxt;
  logic        rup_r, rup_nxt;
  logic        closed_r, closed_nxt;
  logic [13:0] exp_r, exp_nxt;
  logic        eneg_r, eneg_nxt;
  logic        eseen_r, eseen_nxt;
  logic [4:0]  cand_r, cand_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        bad_r, bad_nxt;
  logic        jv_r;
  job_t        job_r, job_nxt;

  logic [7:0]  c, uc;
  logic        is_digit, is_e, is_sign;
  logic [3:0]  d;
  logic        fire, mark;
  logic [62:0] m10;
  logic signed [16:0] sh;

  function automatic logic [7:0] mchar(input int k, input logic [2:0] i);
    logic [7:0] r;
    r = 8'd0;
    case (k)
      0: r = (i == 3'd0) ? 8'h2E : 8'd0;
      1: r = (i == 3'd0) ? 8'h4E : (i == 3'd1) ? 8'h41 : 8'd0;
      2: r = (i == 3'd0) ? 8'h4E : (i == 3'd1) ? 8'h2F : (i == 3'd2) ? 8'h41 : 8'd0;
      3: r = (i == 3'd0) ? 8'h4E : (i == 3'd1) ? 8'h41 : (i == 3'd2) ? 8'h4E : 8'd0;
      default: r = (i == 3'd0) ? 8'h4E : (i == 3'd1) ? 8'h55 :
                   (i == 3'd2) ? 8'h4C : (i == 3'd3) ? 8'h4C : 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] mlen(input int k);
    case (k)
      0: return 3'd1;
      1: return 3'd2;
      2: return 3'd3;
      3: return 3'd3;
      default: return 3'd4;
    endcase
  endfunction

  assign in_ready  = !jv_r || job_ready;
  assign fire      = in_valid && in_ready;
  assign job_valid = jv_r;
  assign job       = job_r;

  always_comb begin
    c        = in_data.field_char;
    uc       = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    is_digit = c >= 8'h30 && c <= 8'h39;
    d        = c[3:0];
    is_e     = c == 8'h65 || c == 8'h45;
    is_sign  = c == 8'h2B || c == 8'h2D;
    m10      = mant_r * 63'd10 + 63'(d);

    phase_nxt = phase_r; neg_nxt = neg_r; mant_nxt = mant_r; frac_nxt = frac_r;
    dseen_nxt = dseen_r; rup_nxt = rup_r; closed_nxt = closed_r; exp_nxt = exp_r;
    eneg_nxt = eneg_r; eseen_nxt = eseen_r; cand_nxt = cand_r; idx_nxt = idx_r;
    bad_nxt = bad_r;

    if (in_data.has_char) begin
      for (int k = 0; k < 5; k++) begin
        if (idx_r >= mlen(k) || mchar(k, idx_r) != uc) cand_nxt[k] = 1'b0;
      end
      if (idx_r < IDX_CAP) idx_nxt = idx_r + 3'd1;
      if (!bad_r) begin
        case (phase_r)
          PH_START, PH_INT: begin
            if (is_sign && phase_r == PH_START) begin
              neg_nxt = c == 8'h2D;
              phase_nxt = PH_INT;
            end else if (is_digit) begin
              if (mant_r > MANT_LIMIT) bad_nxt = 1'b1;
              else begin
                mant_nxt = m10;
                dseen_nxt = 1'b1;
              end
              phase_nxt = PH_INT;
            end else if (c == 8'h2E) phase_nxt = PH_FRAC;
            else if (is_e) phase_nxt = PH_EXPSIGN;
            else bad_nxt = 1'b1;
          end
          PH_FRAC: begin
            if (is_digit) begin
              if (!closed_r && mant_r > MANT_LIMIT) begin
                closed_nxt = 1'b1;
                rup_nxt = d >= 4'd5;
              end else if (!closed_r) begin
                mant_nxt = m10;
                if (frac_r < FRAC_CAP) frac_nxt = frac_r + 15'd1;
              end
              dseen_nxt = 1'b1;
            end else if (is_e) phase_nxt = PH_EXPSIGN;
            else bad_nxt = 1'b1;
          end
          PH_EXPSIGN, PH_EXPDIG: begin
            if (is_sign && phase_r == PH_EXPSIGN) begin
              eneg_nxt = c == 8'h2D;
              phase_nxt = PH_EXPDIG;
            end else if (is_digit) begin
              if (exp_r < EXP_STOP) exp_nxt = exp_r * 14'd10 + 14'(d);
              eseen_nxt = 1'b1;
              phase_nxt = PH_EXPDIG;
            end else bad_nxt = 1'b1;
          end
          default: bad_nxt = 1'b1;
        endcase
      end
    end

    mark = idx_nxt == 3'd0;
    for (int k = 0; k < 5; k++) begin
      if (cand_nxt[k] && idx_nxt == mlen(k)) mark = 1'b1;
    end
    sh = 17'(decimal_places) - $signed({2'b00, frac_nxt}) +
         (eneg_nxt ? -$signed({3'b000, exp_nxt}) : $signed({3'b000, exp_nxt}));
    job_nxt.is_mark  = mark;
    job_nxt.bad      = bad_nxt || idx_nxt == 3'd0 || !dseen_nxt ||
                       phase_nxt == PH_EXPSIGN || (phase_nxt == PH_EXPDIG && !eseen_nxt) ||
                       decimal_places > 5'd18;
    job_nxt.negative = neg_nxt;
    job_nxt.round_up = rup_nxt;
    job_nxt.mantissa = mant_nxt;
    job_nxt.shift    = sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jv_r <= 1'b0;
      phase_r <= PH_START; neg_r <= 1'b0; mant_r <= '0; frac_r <= '0;
      dseen_r <= 1'b0; rup_r <= 1'b0; closed_r <= 1'b0; exp_r <= '0;
      eneg_r <= 1'b0; eseen_r <= 1'b0; cand_r <= 5'h1F; idx_r <= '0; bad_r <= 1'b0;
    end else begin
      if (job_ready) jv_r <= 1'b0;
      if (fire) begin
        if (in_data.last_of_field) begin
          jv_r <= 1'b1;
          job_r <= job_nxt;
          phase_r <= PH_START; neg_r <= 1'b0; mant_r <= '0; frac_r <= '0;
          dseen_r <= 1'b0; rup_r <= 1'b0; closed_r <= 1'b0; exp_r <= '0;
          eneg_r <= 1'b0; eseen_r <= 1'b0; cand_r <= 5'h1F; idx_r <= '0; bad_r <= 1'b0;
        end else begin
          phase_r <= phase_nxt; neg_r <= neg_nxt; mant_r <= mant_nxt; frac_r <= frac_nxt;
          dseen_r <= dseen_nxt; rup_r <= rup_nxt; closed_r <= closed_nxt; exp_r <= exp_nxt;
          eneg_r <= eneg_nxt; eseen_r <= eseen_nxt; cand_r <= cand_nxt; idx_r <= idx_nxt;
          bad_r <= bad_nxt;
        end
      end
    end
  end

endmodule

// File: rtl/core/dfsc_back.sv
module dfsc_back
  import dfsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  input  logic [63:0] value_offset,
  input  logic [1:0]  width_code,
  input  logic        missing_enabled,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  `include "decimal_field_to_scaled_code_unit_assert.svh"

  back_t       st_r, st_nxt;
  logic [63:0] m_r, m_nxt;
  logic [63:0] sc_r, sc_nxt;
  logic [63:0] q_r, q_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] mag_r, mag_nxt;
  out_item_t   res_r, res_nxt;

  logic [63:0] maxv, sv, off, sum, trial;
  logic [4:0]  sh5;
  logic [16:0] nsh;

  always_comb begin
    case (width_code)
      2'd0: maxv = 64'hFF;
      2'd1: maxv = 64'hFFFF;
      2'd2: maxv = 64'hFFFF_FFFF;
      default: maxv = '1;
    endcase
  end

  assign job_ready = st_r == BK_IDLE;
  assign out_valid = st_r == BK_OUT;
  assign out_data  = res_r;

  always_comb begin
    st_nxt = st_r; m_nxt = m_r; sc_nxt = sc_r; q_nxt = q_r; rem_nxt = rem_r;
    cnt_nxt = cnt_r; neg_nxt = neg_r; mag_nxt = mag_r; res_nxt = res_r;
    nsh = -job.shift;
    sh5 = 5'd0;
    trial = {rem_r[62:0], q_r[63]};
    sv = neg_r ? -mag_r : mag_r;
    off = value_offset;
    sum = sv + off;
    case (st_r)
      BK_IDLE: begin
        if (job_valid) begin
          res_nxt = '0;
          neg_nxt = job.negative;
          if (missing_enabled && job.is_mark) begin
            res_nxt.stored_code = maxv;
            res_nxt.missing_marker = 1'b1;
            st_nxt = BK_OUT;
          end else if (job.bad) begin
            res_nxt.status = ST_BAD;
            st_nxt = BK_OUT;
          end else if (job.mantissa == 63'd0) begin
            mag_nxt = '0;
            st_nxt = BK_OFS;
          end else if (!job.shift[16]) begin
            if (job.shift > 17'sd18) begin
              res_nxt.status = ST_BAD;
              st_nxt = BK_OUT;
            end else begin
              sh5 = job.shift[4:0];
              m_nxt = {1'b0, job.mantissa} + 64'(job.round_up);
              if (m_nxt > mul_limit(sh5)) begin
                res_nxt.status = ST_BAD;
                st_nxt = BK_OUT;
              end else begin
                cnt_nxt = {2'b00, sh5};
                st_nxt = BK_MUL;
              end
            end
          end else if (nsh <= 17'sd18) begin
            sh5 = nsh[4:0];
            sc_nxt = ten_pow(sh5);
            q_nxt = {1'b0, job.mantissa};
            rem_nxt = '0;
            cnt_nxt = 7'd64;
            st_nxt = BK_DIV;
          end else begin
            mag_nxt = (nsh == 17'sd19 && {1'b0, job.mantissa} >= 64'd5000000000000000000)
                      ? 64'd1 : 64'd0;
            st_nxt = BK_OFS;
          end
        end
      end
      BK_MUL: begin
        if (cnt_r != 7'd0) begin
          m_nxt = {m_r[60:0], 3'b000} + {m_r[62:0], 1'b0};
          cnt_nxt = cnt_r - 7'd1;
        end else begin
          mag_nxt = m_r;
          st_nxt = BK_OFS;
        end
      end
      BK_DIV: begin
        if (cnt_r != 7'd0) begin
          if (trial >= sc_r) begin
            rem_nxt = trial - sc_r;
            q_nxt = {q_r[62:0], 1'b1};
          end else begin
            rem_nxt = trial;
            q_nxt = {q_r[62:0], 1'b0};
          end
          cnt_nxt = cnt_r - 7'd1;
        end else begin
          mag_nxt = (rem_r >= (sc_r >> 1)) ? q_r + 64'd1 : q_r;
          st_nxt = BK_OFS;
        end
      end
      BK_OFS: begin
        if (!sv[63] && sv != 0 && !off[63] && sum[63]) res_nxt.status = ST_OFFSET;
        else if (sv[63] && off[63] && !sum[63]) res_nxt.status = ST_OFFSET;
        else if (sum[63] || sum > maxv) res_nxt.status = ST_WIDTH;
        else if (missing_enabled && sum == maxv) res_nxt.status = ST_COLLIDE;
        else res_nxt.stored_code = sum;
        st_nxt = BK_OUT;
      end
      BK_OUT: begin
        if (out_ready) st_nxt = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r <= m_nxt; sc_r <= sc_nxt; q_r <= q_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt;
    neg_r <= neg_nxt; mag_r <= mag_nxt; res_r <= res_nxt;
  end

  `DFSC_ASSERT_IMPL(a_ok_zero_status, clk, rst_n,
    out_valid && out_data.status != ST_OK, out_data.stored_code == 64'd0,
    "Failing result carries a nonzero code.")
  `DFSC_ASSERT_IMPL(a_marker_ok, clk, rst_n,
    out_valid && out_data.missing_marker, out_data.status == ST_OK,
    "Missing marker with nonzero status.")
  `DFSC_ASSERT_NEXT(a_hold, clk, rst_n,
    out_valid && !out_ready, out_valid && $stable(out_data),
    "Result changed while stalled.")

endmodule

// File: rtl/core/decimal_field_to_scaled_code_unit.sv
// Converts one decimal text field, one character per input beat, into an
// unsigned scaled code. The parser takes one character per cycle, but it
// stalls while a finished field waits for the busy scaler; after the final
// beat the scaler multiplies by up to 10^18, or divides the value down with
// a 64-step restoring divider, and a one-entry queue lets the parser take
// the next field meanwhile.
module decimal_field_to_scaled_code_unit
  import dfsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [4:0]  dec_r;
  logic [63:0] ofs_r;
  logic [1:0]  wid_r;
  logic        miss_r;
  logic        job_valid, job_ready;
  job_t        job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r <= '0; ofs_r <= '0; wid_r <= '0; miss_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEC:     dec_r  <= cfg_wdata[4:0];
        CFG_OFFSET:  ofs_r  <= cfg_wdata;
        CFG_WIDTH:   wid_r  <= cfg_wdata[1:0];
        CFG_MISSING: miss_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  dfsc_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .decimal_places(dec_r), .job_valid, .job_ready, .job
  );

  dfsc_back u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job,
    .value_offset(ofs_r), .width_code(wid_r), .missing_enabled(miss_r),
    .out_valid, .out_ready, .out_data
  );

endmodule

// File: test/tb_decimal_field_to_scaled_code_unit.sv
`timescale 1ns / 1ps

module tb_decimal_field_to_scaled_code_unit;
  import dfsc_pkg::*;

  localparam longint SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SMIN = 64'sh8000_0000_0000_0000;

  class dec_scoreboard;
    logic [4:0]  dec_places;
    longint      offset;
    logic [1:0]  width_sel;
    bit          miss_en;
    phase_t      phase;
    bit          neg, dseen, rup, closed, eneg, eseen, bad;
    logic [63:0] mant;
    int          frac, expo, idx;
    logic [4:0]  cand;
    out_item_t   pending[$];
    int          errors, beats, results, ok_codes, markers;

    function new();
      dec_places = 0;
      offset = 0;
      width_sel = 0;
      miss_en = 0;
      clear_field();
    endfunction

    function void clear_field();
      phase = PH_START;
      {neg, dseen, rup, closed, eneg, eseen, bad} = '0;
      mant = 0;
      frac = 0;
      expo = 0;
      idx = 0;
      cand = 5'h1F;
    endfunction

    function void set_reg(logic [1:0] index, logic [63:0] value);
      case (index)
        CFG_DEC: dec_places = value[4:0];
        CFG_OFFSET: offset = longint'(value);
        CFG_WIDTH: width_sel = value[1:0];
        CFG_MISSING: miss_en = value[0];
        default: ;
      endcase
    endfunction

    function logic [63:0] pow10(int k);
      logic [63:0] r;
      r = 1;
      repeat (k) r = r * 10;
      return r;
    endfunction

    function void track_marker(logic [7:0] c);
      string mk[5];
      mk = '{".", "NA", "N/A", "NAN", "NULL"};
      if (c >= "a" && c <= "z") c = c - 8'd32;
      for (int k = 0; k < 5; k++) begin
        if (idx >= mk[k].len() || mk[k][idx] != c) cand[k] = 1'b0;
      end
      if (idx < 7) idx++;
    endfunction

    function void take_char(logic [7:0] c);
      bit is_digit, is_e, is_sign;
      logic [63:0] d;
      is_digit = c >= "0" && c <= "9";
      is_e = c == "e" || c == "E";
      is_sign = c == "+" || c == "-";
      d = c - 8'h30;
      track_marker(c);
      if (bad) return;
      case (phase)
        PH_START, PH_INT: begin
          if (is_sign && phase == PH_START) begin
            neg = c == "-";
            phase = PH_INT;
          end else if (is_digit) begin
            if (mant > 64'(MANT_LIMIT)) bad = 1;
            else begin
              mant = mant * 10 + d;
              dseen = 1;
            end
            phase = PH_INT;
          end else if (c == ".") phase = PH_FRAC;
          else if (is_e) phase = PH_EXPSIGN;
          else bad = 1;
        end
        PH_FRAC: begin
          if (is_digit) begin
            if (!closed && mant > 64'(MANT_LIMIT)) begin
              closed = 1;
              rup = d >= 5;
            end
            if (!closed) begin
              mant = mant * 10 + d;
              if (frac < 32767) frac++;
            end
            dseen = 1;
          end else if (is_e) phase = PH_EXPSIGN;
          else bad = 1;
        end
        PH_EXPSIGN, PH_EXPDIG: begin
          if (is_sign && phase == PH_EXPSIGN) begin
            eneg = c == "-";
            phase = PH_EXPDIG;
          end else if (is_digit) begin
            if (expo < 1000) expo = expo * 10 + int'(d);
            eseen = 1;
            phase = PH_EXPDIG;
          end else bad = 1;
        end
        default: bad = 1;
      endcase
    endfunction

    function bit scaled_value(output longint v);
      int shift;
      logic [63:0] m, sc, q, mag;
      v = 0;
      m = mant;
      if (bad || idx == 0 || !dseen || phase == PH_EXPSIGN ||
          (phase == PH_EXPDIG && !eseen) || dec_places > 18) return 0;
      shift = int'(dec_places) - frac + (eneg ? -expo : expo);
      if (m == 0) mag = 0;
      else if (shift >= 0) begin
        if (rup) m = m + 1;
        if (shift > 18) return 0;
        sc = pow10(shift);
        if (m > 64'h7FFF_FFFF_FFFF_FFFF / sc) return 0;
        mag = m * sc;
      end else if (-shift <= 18) begin
        sc = pow10(-shift);
        q = m / sc;
        mag = (m - q * sc >= sc / 2) ? q + 1 : q;
      end else begin
        mag = (-shift == 19 && m >= pow10(18) * 5) ? 1 : 0;
      end
      v = neg ? -longint'(mag) : longint'(mag);
      return 1;
    endfunction

    function out_item_t finish_field();
      out_item_t r;
      logic [63:0] maxv;
      bit is_mark;
      longint v;
      int lens[5];
      lens = '{1, 2, 3, 3, 4};
      maxv = width_sel == 0 ? 64'hFF : width_sel == 1 ? 64'hFFFF :
             width_sel == 2 ? 64'hFFFF_FFFF : '1;
      is_mark = idx == 0;
      for (int k = 0; k < 5; k++) begin
        if (cand[k] && idx == lens[k]) is_mark = 1;
      end
      r = '0;
      if (miss_en && is_mark) begin
        r.stored_code = maxv;
        r.missing_marker = 1;
      end else if (!scaled_value(v)) r.status = ST_BAD;
      else if ((v > 0 && offset > SMAX - v) || (v < 0 && offset < SMIN - v))
        r.status = ST_OFFSET;
      else begin
        v = v + offset;
        if (v < 0 || 64'(v) > maxv) r.status = ST_WIDTH;
        else if (miss_en && 64'(v) == maxv) r.status = ST_COLLIDE;
        else r.stored_code = 64'(v);
      end
      return r;
    endfunction

    function void note_beat(in_item_t it);
      beats++;
      if (it.has_char) take_char(it.field_char);
      if (it.last_of_field) begin
        pending.push_back(finish_field());
        clear_field();
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      results++;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %p", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.stored_code !== exp_r.stored_code) begin
        $error("stored_code expected %0d actual %0d", exp_r.stored_code, got.stored_code);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $error("status expected %0d actual %0d", exp_r.status, got.status);
        errors++;
      end
      if (got.missing_marker !== exp_r.missing_marker) begin
        $error("missing_marker expected %0d actual %0d", exp_r.missing_marker,
               got.missing_marker);
        errors++;
      end
      if (exp_r.status == ST_OK) ok_codes++;
      if (exp_r.missing_marker) markers++;
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_ready, out_valid, out_ready;
  in_item_t    in_data;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wdata;

  dec_scoreboard sb = new();
  int burst_left;
  typedef byte unsigned text_q_t[$];

  decimal_field_to_scaled_code_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_beat(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  initial begin
    int cyc, mode;
    out_ready = 0;
    cyc = 0;
    mode = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 2);
      if (cyc >= 3000 && cyc < 3400) out_ready <= 0;
      else if (mode == 0) out_ready <= 1;
      else if (mode == 1) out_ready <= $urandom_range(0, 1);
      else out_ready <= $urandom_range(0, 3) == 0;
    end
  end

  task automatic send_beat(in_item_t it);
    if (burst_left == 0) begin
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_field(text_q_t txt, bit end_empty);
    in_item_t it;
    foreach (txt[i]) begin
      if ($urandom_range(0, 24) == 0) begin
        it.field_char = $urandom_range(0, 255);
        it.has_char = 0;
        it.last_of_field = 0;
        send_beat(it);
      end
      it.field_char = txt[i];
      it.has_char = 1;
      it.last_of_field = (i == txt.size() - 1) && !end_empty;
      send_beat(it);
    end
    if (end_empty || txt.size() == 0) begin
      it.field_char = $urandom_range(0, 255);
      it.has_char = 0;
      it.last_of_field = 1;
      send_beat(it);
    end
  endtask

  task automatic send_text(string s);
    text_q_t txt;
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    send_field(txt, 0);
  endtask

  task automatic write_reg(logic [1:0] index, logic [63:0] value);
    cfg_we <= 1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(index, value);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic add_digits(ref text_q_t txt, input int n);
    repeat (n) txt.push_back(8'h30 + $urandom_range(0, 9));
  endtask

  task automatic random_field();
    text_q_t txt;
    string marks[6];
    string s;
    int kind;
    marks = '{".", "NA", "n/a", "NaN", "null", "nUlL"};
    kind = $urandom_range(0, 19);
    if (kind < 14) begin
      case ($urandom_range(0, 3))
        0: txt.push_back("-");
        1: txt.push_back("+");
        default: ;
      endcase
      add_digits(txt, $urandom_range(0, 3) == 0 ? $urandom_range(0, 21) :
                 $urandom_range(0, 4));
      if ($urandom_range(0, 1)) begin
        txt.push_back(".");
        add_digits(txt, $urandom_range(0, 5) == 0 ? $urandom_range(0, 25) :
                   $urandom_range(0, 4));
      end
      if ($urandom_range(0, 3) == 0) begin
        txt.push_back($urandom_range(0, 1) ? "e" : "E");
        if ($urandom_range(0, 1)) txt.push_back($urandom_range(0, 1) ? "-" : "+");
        add_digits(txt, $urandom_range(0, 2));
      end
    end else if (kind < 16) begin
      s = marks[$urandom_range(0, 5)];
      for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    end else if (kind < 17) begin
    end else begin
      repeat ($urandom_range(1, 6)) txt.push_back($urandom_range(0, 255));
      if ($urandom_range(0, 1)) txt[$urandom_range(0, txt.size() - 1)] = "1";
    end
    send_field(txt, $urandom_range(0, 7) == 0);
  endtask

  initial begin
    logic [63:0] offs[6];
    int target;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = CFG_DEC;
    cfg_wdata = '0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    write_reg(CFG_DEC, 2);
    write_reg(CFG_OFFSET, 0);
    write_reg(CFG_WIDTH, 3);
    write_reg(CFG_MISSING, 1);
    send_text("0");
    send_text("-0");
    send_text("+12.5");
    send_text("1e3");
    send_text("1.5E-1");
    send_text("9223372036854775807");
    send_text("99999999999999999999");
    send_text("1.23456789012345678901234");
    send_text("0.9223372036854775807999");
    send_text(".");
    send_text("NA");
    send_text("n/a");
    send_text("NaN");
    send_text("null");
    send_text("");
    send_text("abc");
    send_text("1e");
    send_text("1e+");
    send_text("-");
    send_text("12.34e-2");
    send_text("5000000000000000000e-21");
    send_text("1e99999");
    send_text("184467440737095516.15");
    drain();
    write_reg(CFG_DEC, 31);
    send_text("NULL");
    send_text("7");
    drain();

    offs = '{64'd0, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
             64'd100, -64'd50, 64'hFFFF_FFFF_FFFF_FFFF};
    target = 0;
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_DEC, ph == 0 ? 0 : ph == 1 ? 18 : ph == 2 ? 19 :
                $urandom_range(0, 4));
      write_reg(CFG_OFFSET, ph < 6 ? offs[ph] : offs[$urandom_range(0, 5)]);
      write_reg(CFG_WIDTH, ph < 4 ? ph : $urandom_range(0, 3));
      write_reg(CFG_MISSING, ph % 2);
      target = sb.beats + 50;
      while (sb.beats < target) random_field();
      drain();
    end

    $display("Checked %0d results from %0d input beats across 10 register settings.",
             sb.results, sb.beats);
    $display("%0d fields gave a usable code and %0d were taken as missing.",
             sb.ok_codes, sb.markers);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
